>>> rtl/core/ofer_pkg.sv
// shared constants, types and latencies of the orbit frame rotation block
package ofer_pkg;

   localparam int AXIS_FRAC_BITS = 30;
   localparam int POS_W          = 32;
   localparam int TRACK_W        = 18;
   localparam int OUT_W          = 18;
   localparam int OUT_LIMIT      = 113512;

   localparam int WIDE_W   = 64;
   localparam int MAG_W    = 30;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int RAD_W    = SQ_W + 2;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int UNIT_W   = 32;

   localparam int CROSS_LAT = 2;
   localparam int SQRT_LAT  = ROOT_W + 1;
   localparam int DIV_LAT   = ROOT_W + 2;
   localparam int NORM_LAT  = 4 + SQRT_LAT + DIV_LAT;

   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef unit_type [2:0] unit_vec_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef wide_type [2:0] wide_vec_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  zero;
   } norm_carry_type;

endpackage

>>> rtl/core/orbit_frame_to_equatorial_rotation.sv
// top level: satellite frame build and rotation of the particle direction
//
// usage
//   req channel: one transaction carries satellite position, satellite
//   velocity and track direction (orbit frame, q1.16). rsp channel: one
//   transaction per request with the particle direction in equatorial
//   axes (q1.16, saturated to +-113512) and a degenerate flag in tuser.
//   the block builds z = -unit(pos), y = unit(vel x pos), x = unit(y x z)
//   and returns x*px + y*py + z*pz with p = -track.
// pipeline and throughput
//   one transaction per cycle sustained while rsp_tready does not hold off
//   the output register. the pipeline runs through the input register, two
//   normalizer pipelines in series (one root bit and one quotient bit per
//   stage), two cross product stages each, the output products and sums
//   and the output register.
// reset and stall
//   reset empties the pipeline; no state survives between transactions.
//   the output register holds a response while rsp_tready is low; the
//   pipeline keeps moving (and req_tready stays high) while its last stage
//   is empty, so bubbles are squeezed out before the input is held off.
module orbit_frame_to_equatorial_rotation (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sat_pos_x, sat_pos_y, sat_pos_z, sat_vel_x, sat_vel_y, sat_vel_z,
   // track_dir_x, track_dir_y, track_dir_z, two zero bits
   input  logic [247:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // particle_eq_x, particle_eq_y, particle_eq_z, two zero bits
   output logic [55:0]  rsp_tdata,
   // degenerate
   output logic [0:0]   rsp_tuser
);

   localparam int PW       = ofer_pkg::POS_W;
   localparam int TW       = ofer_pkg::TRACK_W;
   localparam int OW       = ofer_pkg::OUT_W;
   localparam int VEL_LSB  = 3 * PW;
   localparam int TRK_LSB  = 6 * PW;
   localparam int ZX_DLY   = ofer_pkg::CROSS_LAT;
   localparam int AX_DLY   = ofer_pkg::CROSS_LAT + ofer_pkg::NORM_LAT;
   localparam int TRK_DLY  = 2 * AX_DLY;
   localparam int PD_W     = TW + 1;
   localparam int PROD_W   = ofer_pkg::UNIT_W + PD_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(1) << (ofer_pkg::AXIS_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(ofer_pkg::OUT_LIMIT);

   typedef struct packed {
      ofer_pkg::unit_vec_type zx;
      logic                   deg;
   } zx_tap_type;

   typedef struct packed {
      ofer_pkg::unit_vec_type ya;
      ofer_pkg::unit_vec_type zx;
      logic                   deg;
   } axes_tap_type;

   typedef logic [2:0][TW-1:0] track_vec_type;

   logic advance;
   logic last_vld;

   // input register
   ofer_pkg::unit_vec_type in_pos_ff;
   ofer_pkg::unit_vec_type in_vel_ff;
   track_vec_type          in_trk_ff;
   logic                   in_vld_ff;
   ofer_pkg::wide_vec_type pos_wide;

   // z axis path
   ofer_pkg::unit_vec_type z_unit;
   logic                   z_deg;
   zx_tap_type             zx_tap_in;
   zx_tap_type             zx_dly_ff [ZX_DLY];

   // y axis path
   ofer_pkg::wide_vec_type n_vec;
   logic                   n_vld;
   ofer_pkg::unit_vec_type ya;
   logic                   ya_vld;
   logic                   ya_deg;

   // x axis path
   ofer_pkg::wide_vec_type m_vec;
   logic                   m_vld;
   ofer_pkg::unit_vec_type xa;
   logic                   xa_vld;
   logic                   xa_deg;

   axes_tap_type           ax_tap_in;
   axes_tap_type           ax_dly_ff [AX_DLY];
   track_vec_type          trk_dly_ff [TRK_DLY];

   // output arithmetic
   logic signed [PD_W-1:0]   pdir [3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic                     o1_deg_ff;
   logic                     o1_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic                     o2_deg_ff;
   logic                     o2_vld_ff;
   logic signed [ACC_W-1:0]  shifted [3];
   logic [2:0][OW-1:0]       sat_val;
   logic [2:0][OW-1:0]       rsp_val_ff;
   logic                     rsp_deg_ff;
   logic                     rsp_vld_ff;

   // the pipeline moves whenever its last stage can empty or is empty
   assign last_vld   = o2_vld_ff;
   assign advance    = !last_vld || !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (advance) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            in_pos_ff[i] <= req_tdata[i*PW +: PW];
            in_vel_ff[i] <= req_tdata[VEL_LSB + i*PW +: PW];
            in_trk_ff[i] <= req_tdata[TRK_LSB + i*TW +: TW];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_wide[i] = ofer_pkg::WIDE_W'($signed(in_pos_ff[i]));
      end
   end

   // z axis: unit of the position, negated below
   ofer_norm u_norm_z (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (in_vld_ff),
      .vec        (pos_wide),
      .out_valid  (),
      .unit_vec   (z_unit),
      .degenerate (z_deg)
   );

   // y axis: unit of vel x pos
   ofer_cross u_cross_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (in_vld_ff),
      .a         (in_vel_ff),
      .b         (in_pos_ff),
      .out_valid (n_vld),
      .c         (n_vec)
   );

   ofer_norm u_norm_y (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (n_vld),
      .vec        (n_vec),
      .out_valid  (ya_vld),
      .unit_vec   (ya),
      .degenerate (ya_deg)
   );

   // line up z with y (the y path has the extra cross product)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         zx_tap_in.zx[i] = -z_unit[i];
      end
      zx_tap_in.deg = z_deg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zx_dly_ff[0] <= zx_tap_in;
         for (int k = 1; k < ZX_DLY; k++) begin
            zx_dly_ff[k] <= zx_dly_ff[k-1];
         end
      end
   end

   // x axis: unit of y x z
   ofer_cross u_cross_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (ya_vld),
      .a         (ya),
      .b         (zx_dly_ff[ZX_DLY-1].zx),
      .out_valid (m_vld),
      .c         (m_vec)
   );

   ofer_norm u_norm_x (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (m_vld),
      .vec        (m_vec),
      .out_valid  (xa_vld),
      .unit_vec   (xa),
      .degenerate (xa_deg)
   );

   // hold y, z and the flags until x is ready, and the track until then too
   always_comb begin
      ax_tap_in.ya  = ya;
      ax_tap_in.zx  = zx_dly_ff[ZX_DLY-1].zx;
      ax_tap_in.deg = ya_deg | zx_dly_ff[ZX_DLY-1].deg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_dly_ff[0]  <= ax_tap_in;
         trk_dly_ff[0] <= in_trk_ff;
         for (int k = 1; k < AX_DLY; k++) begin
            ax_dly_ff[k] <= ax_dly_ff[k-1];
         end
         for (int k = 1; k < TRK_DLY; k++) begin
            trk_dly_ff[k] <= trk_dly_ff[k-1];
         end
      end
   end

   // particle direction is the negated track; columns x, y, z
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pdir[j] = -PD_W'($signed(trk_dly_ff[TRK_DLY-1][j]));
      end
      for (int i = 0; i < 3; i++) begin
         prod_in[i][0] = $signed(xa[i]) * pdir[0];
         prod_in[i][1] = $signed(ax_dly_ff[AX_DLY-1].ya[i]) * pdir[1];
         prod_in[i][2] = $signed(ax_dly_ff[AX_DLY-1].zx[i]) * pdir[2];
      end
   end

   // round half up by floor shift, then saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted[i] = acc_ff[i] >>> ofer_pkg::AXIS_FRAC_BITS;
         if (shifted[i] > SAT_HI) begin
            sat_val[i] = OW'(ofer_pkg::OUT_LIMIT);
         end else if (shifted[i] < -SAT_HI) begin
            sat_val[i] = OW'(-ofer_pkg::OUT_LIMIT);
         end else begin
            sat_val[i] = shifted[i][OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o1_vld_ff <= 1'b0;
         o2_vld_ff <= 1'b0;
      end else if (advance) begin
         o1_vld_ff <= xa_vld;
         o2_vld_ff <= o1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         o1_deg_ff <= xa_deg | ax_dly_ff[AX_DLY-1].deg;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= ACC_W'(prod_ff[i][0]) + ACC_W'(prod_ff[i][1])
                         + ACC_W'(prod_ff[i][2]) + ROUND_HALF;
         end
         o2_deg_ff <= o1_deg_ff;
      end
   end

   // output register: loads when the slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (!rsp_vld_ff || rsp_tready) begin
         rsp_vld_ff <= last_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_vld_ff || rsp_tready) begin
         rsp_val_ff <= sat_val;
         rsp_deg_ff <= o2_deg_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_val_ff};
   assign rsp_tuser  = rsp_deg_ff;

endmodule

>>> rtl/core/ofer_cross.sv
// two stage registered cross product c = a x b
module ofer_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  ofer_pkg::unit_vec_type a,
   input  ofer_pkg::unit_vec_type b,
   output logic                  out_valid,
   output ofer_pkg::wide_vec_type c
);

   logic signed [ofer_pkg::WIDE_W-1:0] prod_in [6];
   logic signed [ofer_pkg::WIDE_W-1:0] prod_ff [6];
   logic                               prod_vld_ff;
   ofer_pkg::wide_vec_type             c_ff;
   logic                               c_vld_ff;

   always_comb begin
      prod_in[0] = $signed(a[1]) * $signed(b[2]);
      prod_in[1] = $signed(a[2]) * $signed(b[1]);
      prod_in[2] = $signed(a[2]) * $signed(b[0]);
      prod_in[3] = $signed(a[0]) * $signed(b[2]);
      prod_in[4] = $signed(a[0]) * $signed(b[1]);
      prod_in[5] = $signed(a[1]) * $signed(b[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         c_vld_ff    <= 1'b0;
      end else if (advance) begin
         prod_vld_ff <= in_valid;
         c_vld_ff    <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         c_ff[0] <= prod_ff[0] - prod_ff[1];
         c_ff[1] <= prod_ff[2] - prod_ff[3];
         c_ff[2] <= prod_ff[4] - prod_ff[5];
      end
   end

   assign out_valid = c_vld_ff;
   assign c         = c_ff;

endmodule

>>> rtl/core/ofer_isqrt.sv
// pipelined integer square root, one root bit per stage
module ofer_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [ofer_pkg::RAD_W-1:0]   radicand,
   input  ofer_pkg::norm_carry_type     in_carry,
   output logic                         out_valid,
   output logic [ofer_pkg::ROOT_W-1:0]  root,
   output ofer_pkg::norm_carry_type     out_carry
);

   localparam int LAT   = ofer_pkg::SQRT_LAT;
   localparam int REM_W = ofer_pkg::ROOT_W + 2;

   typedef struct packed {
      logic [ofer_pkg::RAD_W-1:0]  rad;
      logic [REM_W-1:0]            rem;
      logic [ofer_pkg::ROOT_W-1:0] root;
      ofer_pkg::norm_carry_type    carry;
   } sqrt_stage_type;

   sqrt_stage_type   stage_ff [LAT];
   logic [LAT-1:0]   vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0].rad   <= radicand;
         stage_ff[0].rem   <= '0;
         stage_ff[0].root  <= '0;
         stage_ff[0].carry <= in_carry;
      end
   end

   for (genvar k = 0; k < LAT - 1; k++) begin : g_step
      logic [REM_W+1:0] cand;
      logic [REM_W-1:0] trial;
      sqrt_stage_type   next_in;

      always_comb begin
         cand    = {stage_ff[k].rem, stage_ff[k].rad[ofer_pkg::RAD_W-1-2*k -: 2]};
         trial   = {stage_ff[k].root, 2'b01};
         next_in = stage_ff[k];
         if (cand >= {2'b00, trial}) begin
            next_in.rem  = REM_W'(cand - {2'b00, trial});
            next_in.root = {stage_ff[k].root[ofer_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            next_in.rem  = cand[REM_W-1:0];
            next_in.root = {stage_ff[k].root[ofer_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[k+1] <= next_in;
         end
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign root      = stage_ff[LAT-1].root;
   assign out_carry = stage_ff[LAT-1].carry;

endmodule

>>> rtl/core/ofer_div.sv
// pipelined three lane rounded divide of the magnitudes by the root, then sign
module ofer_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [ofer_pkg::ROOT_W-1:0] divisor,
   input  ofer_pkg::norm_carry_type    in_carry,
   output logic                        out_valid,
   output ofer_pkg::unit_vec_type      quot,
   output logic                        degenerate
);

   localparam int RW    = ofer_pkg::ROOT_W;
   localparam int STEPS = RW;
   localparam int DVD_W = ofer_pkg::MAG_W + ofer_pkg::AXIS_FRAC_BITS + 1;

   typedef struct packed {
      logic [2:0][RW-1:0] rem;
      logic [2:0][RW-1:0] low;
      logic [2:0][RW-1:0] q;
      logic [RW-1:0]      div;
      logic [2:0]         neg;
      logic               zero;
   } div_stage_type;

   div_stage_type          stage_ff [STEPS+1];
   div_stage_type          prep_in;
   logic [DVD_W-1:0]       dividend [3];
   logic [STEPS+1:0]       vld_ff;
   ofer_pkg::unit_vec_type quot_ff;
   logic                   deg_ff;

   always_comb begin
      prep_in      = '0;
      prep_in.div  = divisor;
      prep_in.neg  = in_carry.neg;
      prep_in.zero = in_carry.zero;
      for (int i = 0; i < 3; i++) begin
         dividend[i] = (DVD_W'(in_carry.mag[i]) << ofer_pkg::AXIS_FRAC_BITS)
                       + DVD_W'(divisor[RW-1:1]);
         prep_in.rem[i] = RW'(dividend[i][DVD_W-1:RW]);
         prep_in.low[i] = dividend[i][RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STEPS:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= prep_in;
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      div_stage_type next_in;
      logic [RW:0]   cand [3];

      always_comb begin
         next_in = stage_ff[j];
         for (int i = 0; i < 3; i++) begin
            cand[i] = {stage_ff[j].rem[i], stage_ff[j].low[i][RW-1-j]};
            if (cand[i] >= {1'b0, stage_ff[j].div}) begin
               next_in.rem[i] = RW'(cand[i] - {1'b0, stage_ff[j].div});
               next_in.q[i]   = {stage_ff[j].q[i][RW-2:0], 1'b1};
            end else begin
               next_in.rem[i] = cand[i][RW-1:0];
               next_in.q[i]   = {stage_ff[j].q[i][RW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[j+1] <= next_in;
         end
      end
   end

   // sign and zero vector handling
   always_ff @(posedge clock) begin
      if (advance) begin
         deg_ff <= stage_ff[STEPS].zero;
         for (int i = 0; i < 3; i++) begin
            if (stage_ff[STEPS].zero) begin
               quot_ff[i] <= '0;
            end else if (stage_ff[STEPS].neg[i]) begin
               quot_ff[i] <= -ofer_pkg::UNIT_W'({1'b0, stage_ff[STEPS].q[i]});
            end else begin
               quot_ff[i] <= ofer_pkg::UNIT_W'({1'b0, stage_ff[STEPS].q[i]});
            end
         end
      end
   end

   assign out_valid  = vld_ff[STEPS+1];
   assign quot       = quot_ff;
   assign degenerate = deg_ff;

endmodule

>>> rtl/core/ofer_norm.sv
// vector normalization pipeline: magnitude scaling, squares, root, divide
module ofer_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  ofer_pkg::wide_vec_type vec,
   output logic                   out_valid,
   output ofer_pkg::unit_vec_type unit_vec,
   output logic                   degenerate
);

   localparam int MW = ofer_pkg::WIDE_W - 1;
   localparam int LZ_W = $clog2(MW);
   localparam int MAG_W = ofer_pkg::MAG_W;

   logic [2:0][MW-1:0]    mag_in;
   logic [2:0][MW-1:0]    n1_mag_ff;
   logic [2:0]            n1_neg_ff;
   logic                  n1_vld_ff;

   logic [MW-1:0]         mag_or;
   logic [LZ_W-1:0]       lz_in;
   logic [2:0][MW-1:0]    n2_mag_ff;
   logic [2:0]            n2_neg_ff;
   logic [LZ_W-1:0]       n2_lz_ff;
   logic                  n2_zero_ff;
   logic                  n2_vld_ff;

   logic [MW-1:0]         shifted [3];
   logic [2:0][MAG_W-1:0] n3_mag_ff;
   logic [2:0]            n3_neg_ff;
   logic                  n3_zero_ff;
   logic                  n3_vld_ff;

   logic [ofer_pkg::SQ_W-1:0] n4_sq_ff [3];
   ofer_pkg::norm_carry_type  n4_carry_ff;
   logic                      n4_vld_ff;

   logic [ofer_pkg::RAD_W-1:0]  sum_sq;
   logic                        sq_vld;
   logic [ofer_pkg::ROOT_W-1:0] root;
   ofer_pkg::norm_carry_type    sq_carry;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (vec[i][ofer_pkg::WIDE_W-1]) begin
            mag_in[i] = MW'(-vec[i]);
         end else begin
            mag_in[i] = vec[i][MW-1:0];
         end
      end
   end

   // leading one of the largest magnitude is the leading one of their or
   always_comb begin
      mag_or = n1_mag_ff[0] | n1_mag_ff[1] | n1_mag_ff[2];
      lz_in  = '0;
      for (int i = 0; i < MW; i++) begin
         if (mag_or[i]) begin
            lz_in = LZ_W'(MW - 1 - i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted[i] = n2_mag_ff[i] << n2_lz_ff;
      end
      sum_sq = ofer_pkg::RAD_W'(n4_sq_ff[0]) + ofer_pkg::RAD_W'(n4_sq_ff[1])
               + ofer_pkg::RAD_W'(n4_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_vld_ff <= 1'b0;
         n2_vld_ff <= 1'b0;
         n3_vld_ff <= 1'b0;
         n4_vld_ff <= 1'b0;
      end else if (advance) begin
         n1_vld_ff <= in_valid;
         n2_vld_ff <= n1_vld_ff;
         n3_vld_ff <= n2_vld_ff;
         n4_vld_ff <= n3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_mag_ff  <= mag_in;
         for (int i = 0; i < 3; i++) begin
            n1_neg_ff[i] <= vec[i][ofer_pkg::WIDE_W-1];
         end
         n2_mag_ff  <= n1_mag_ff;
         n2_neg_ff  <= n1_neg_ff;
         n2_lz_ff   <= lz_in;
         n2_zero_ff <= (mag_or == '0);
         for (int i = 0; i < 3; i++) begin
            n3_mag_ff[i] <= shifted[i][MW-1 -: MAG_W];
         end
         n3_neg_ff  <= n2_neg_ff;
         n3_zero_ff <= n2_zero_ff;
         for (int i = 0; i < 3; i++) begin
            n4_sq_ff[i] <= n3_mag_ff[i] * n3_mag_ff[i];
         end
         n4_carry_ff.mag  <= n3_mag_ff;
         n4_carry_ff.neg  <= n3_neg_ff;
         n4_carry_ff.zero <= n3_zero_ff;
      end
   end

   ofer_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (n4_vld_ff),
      .radicand  (sum_sq),
      .in_carry  (n4_carry_ff),
      .out_valid (sq_vld),
      .root      (root),
      .out_carry (sq_carry)
   );

   ofer_div u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (sq_vld),
      .divisor    (root),
      .in_carry   (sq_carry),
      .out_valid  (out_valid),
      .quot       (unit_vec),
      .degenerate (degenerate)
   );

endmodule
